// File: hw/rtl/wbps_pkg.sv
package wbps_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);
  localparam int SEEN_W = 17;
  localparam int ADDR_W = 16;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 17'h1ffff;
  localparam logic [ADDR_W-1:0] ADDR_MASK = 16'hffff;
  localparam logic [ADDR_W-1:0] BASE_RESET = 16'h0100;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_IMAGE = 2'd2;

  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ANCHORED = 2'd1;
  localparam logic [1:0] REG_ANCHOR_ADDRESS = 2'd2;

  typedef struct packed {
    logic       clear;
    logic       append;
    logic       push;
    logic [7:0] element_value;
    logic       element_is_any;
    logic [7:0] image_byte;
  } row_ctrl_t;

  typedef struct packed {
    logic       valid;
    logic       is_any;
    logic [7:0] value;
    logic [7:0] window;
  } cell_link_t;

endpackage

// File: hw/rtl/wbps_cell.sv
module wbps_cell (
  input  logic                clk,
  input  logic                rst,
  input  wbps_pkg::row_ctrl_t  ctrl,
  input  wbps_pkg::cell_link_t link_in,
  output wbps_pkg::cell_link_t link_out,
  output logic                ok
);

  logic       valid;
  logic       is_any;
  logic [7:0] value;
  logic [7:0] window;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.append) begin
      valid <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append) begin
      is_any <= link_in.is_any;
      value  <= link_in.value;
    end
    if (ctrl.push) begin
      window <= link_in.window;
    end
  end

  assign ok = !valid || is_any || (value == link_in.window);

  assign link_out.valid  = valid;
  assign link_out.is_any = is_any;
  assign link_out.value  = value;
  assign link_out.window = window;

endmodule

// File: hw/rtl/wbps_row.sv
module wbps_row (
  input  logic               clk,
  input  logic               rst,
  input  wbps_pkg::row_ctrl_t ctrl,
  output logic               match,
  output logic               full
);

  wbps_pkg::cell_link_t links [0:wbps_pkg::PATTERN_DEPTH];
  logic [wbps_pkg::PATTERN_DEPTH-1:0] ok;

  assign links[0].valid  = 1'b1;
  assign links[0].is_any = ctrl.element_is_any;
  assign links[0].value  = ctrl.element_value;
  assign links[0].window = ctrl.image_byte;

  for (genvar k = 0; k < wbps_pkg::PATTERN_DEPTH; k++) begin : g_cell
    wbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .link_in  (links[k]),
      .link_out (links[k+1]),
      .ok       (ok[k])
    );
  end

  assign match = &ok;
  assign full  = links[wbps_pkg::PATTERN_DEPTH].valid;

endmodule

// File: hw/rtl/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search. The pattern sits in a row of cells, newest
// element in the first cell, and image bytes shift through the same row, so
// every cell compares its element against the aligned byte in the cycle the
// byte arrives. One item is taken every clock cycle; the input stalls only
// while a finished result waits in the output register and the sink holds
// tready low. The result of the last image byte is registered and appears in
// the cycle after that byte is taken. There is no clearing pass after reset.
module wildcard_byte_pattern_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] element_value, [8] element_is_any, [16:9] image_byte, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] hit, [1] multiple_hit, [17:2] match_address, [23:18] zero
  output logic [23:0] m_axis_tdata
);

  localparam int SW = wbps_pkg::SEEN_W;

  logic [wbps_pkg::ADDR_W-1:0] base_address;
  logic                        anchored;
  logic [wbps_pkg::ADDR_W-1:0] anchor_address;

  logic [wbps_pkg::LEN_W-1:0]  pattern_length;
  logic [SW-1:0]               bytes_seen;
  logic                        found;
  logic                        found_twice;
  logic [wbps_pkg::ADDR_W-1:0] last_addr;

  logic                        out_valid;
  logic                        out_hit;
  logic                        out_multi;
  logic [wbps_pkg::ADDR_W-1:0] out_addr;

  wbps_pkg::row_ctrl_t ctrl;
  logic                match;
  logic                full;
  logic                in_ok;

  logic [SW:0]                 seen_plus;
  logic [SW:0]                 start;
  logic [wbps_pkg::ADDR_W-1:0] addr;
  logic                        test;
  logic                        hit_now;
  logic                        found_next;
  logic                        twice_next;
  logic [wbps_pkg::ADDR_W-1:0] last_next;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_ok = s_axis_tvalid && s_axis_tready;

  assign ctrl.clear          = in_ok && (s_axis_tuser == wbps_pkg::MODE_CLEAR);
  assign ctrl.append         = in_ok && (s_axis_tuser == wbps_pkg::MODE_APPEND) && !full;
  assign ctrl.push           = in_ok && (s_axis_tuser == wbps_pkg::MODE_IMAGE);
  assign ctrl.element_value  = s_axis_tdata[7:0];
  assign ctrl.element_is_any = s_axis_tdata[8];
  assign ctrl.image_byte     = s_axis_tdata[16:9];

  wbps_row u_row (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .match (match),
    .full  (full)
  );

  always_comb begin
    seen_plus  = {1'b0, bytes_seen} + (SW+1)'(1);
    start      = seen_plus - (SW+1)'(pattern_length);
    addr       = (base_address + start[wbps_pkg::ADDR_W-1:0]) & wbps_pkg::ADDR_MASK;
    test       = (pattern_length != '0) && (seen_plus >= (SW+1)'(pattern_length));
    hit_now    = test && (!anchored || (addr == anchor_address)) && match;
    found_next = found || hit_now;
    twice_next = found_twice || (found && hit_now);
    last_next  = hit_now ? addr : last_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= wbps_pkg::BASE_RESET;
      anchored       <= 1'b0;
      anchor_address <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_BASE_ADDRESS:   base_address   <= cfg_data;
        wbps_pkg::REG_ANCHORED:       anchored       <= cfg_data[0];
        wbps_pkg::REG_ANCHOR_ADDRESS: anchor_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      bytes_seen     <= '0;
      found          <= 1'b0;
      found_twice    <= 1'b0;
      last_addr      <= '0;
    end else if (ctrl.clear) begin
      pattern_length <= '0;
      bytes_seen     <= '0;
      found          <= 1'b0;
      found_twice    <= 1'b0;
      last_addr      <= '0;
    end else if (ctrl.append) begin
      pattern_length <= pattern_length + wbps_pkg::LEN_W'(1);
    end else if (ctrl.push) begin
      if (s_axis_tlast) begin
        bytes_seen  <= '0;
        found       <= 1'b0;
        found_twice <= 1'b0;
        last_addr   <= '0;
      end else begin
        if (bytes_seen != wbps_pkg::SEEN_MAX) begin
          bytes_seen <= bytes_seen + SW'(1);
        end
        found       <= found_next;
        found_twice <= twice_next;
        last_addr   <= last_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.push && s_axis_tlast) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && s_axis_tlast) begin
      out_hit   <= found_next;
      out_multi <= twice_next;
      out_addr  <= found_next ? last_next : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_addr, out_multi, out_hit};

endmodule

// File: tb/tb_wildcard_byte_pattern_search.sv
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_search;
  import wbps_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEM_TARGET = 1350;
  localparam int LONG_STREAM = 40;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] value;
    logic       wild;
    logic [7:0] img;
    logic       is_last;
  } search_item_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        multi;
    logic        hit;
  } search_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BASE_ADDRESS;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] element_value, [8] element_is_any, [16:9] image_byte, [23:17] zero
  logic [23:0] s_axis_tdata = '0;
  // [1:0] mode
  logic [1:0]  s_axis_tuser = MODE_CLEAR;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] hit, [1] multiple_hit, [17:2] match_address, [23:18] zero
  logic [23:0] m_axis_tdata;

  wildcard_byte_pattern_search u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // search state mirror
  logic [15:0]       base_reg;
  logic              anchored_reg;
  logic [15:0]       anchor_reg;
  logic [8:0]        pat_store [PATTERN_DEPTH];
  int unsigned       pat_len;
  logic [7:0]        win [PATTERN_DEPTH];
  logic [SEEN_W-1:0] seen;
  logic              found;
  logic              found_twice;
  logic [15:0]       last_addr;

  search_item_t   item_queue[$];
  search_report_t expected_reports[$];
  logic [8:0]     plan_pat[$];
  search_item_t   next_item;
  search_report_t want;

  int items_sent = 0;
  int items_taken = 0;
  int stim_count = 0;
  int results_seen = 0;
  int mismatches = 0;
  int phases = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit calm = 1'b0;
  bit quiet = 1'b0;

  task automatic clear_stream();
    for (int i = 0; i < PATTERN_DEPTH; i++) win[i] = 8'h00;
    seen = '0;
    found = 1'b0;
    found_twice = 1'b0;
    last_addr = '0;
  endtask

  task automatic search_step(input search_item_t it);
    logic [SEEN_W-1:0] start;
    logic [15:0]       addr;
    bit                ok;
    search_report_t    rep;
    case (it.mode)
      MODE_CLEAR: begin
        pat_len = 0;
        clear_stream();
      end
      MODE_APPEND: begin
        if (pat_len < PATTERN_DEPTH) begin
          pat_store[pat_len] = {it.wild, it.value};
          pat_len++;
        end
      end
      MODE_IMAGE: begin
        for (int i = PATTERN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = it.img;
        if (pat_len != 0 && seen + 1 >= pat_len) begin
          start = SEEN_W'(seen + 1 - pat_len);
          addr = base_reg + start[15:0];
          ok = 1'b1;
          for (int i = 0; i < pat_len; i++)
            if (!pat_store[i][8] && pat_store[i][7:0] != win[pat_len-1-i]) ok = 1'b0;
          if (ok && (!anchored_reg || addr == anchor_reg)) begin
            if (found) found_twice = 1'b1;
            found = 1'b1;
            last_addr = addr;
          end
        end
        if (seen < SEEN_MAX) seen++;
        if (it.is_last) begin
          rep.hit = found;
          rep.multi = found_twice;
          rep.addr = found ? last_addr : 16'h0000;
          expected_reports.push_back(rep);
          clear_stream();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      base_reg = BASE_RESET;
      anchored_reg = 1'b0;
      anchor_reg = '0;
      pat_len = 0;
      clear_stream();
    end else begin
      if (cfg_we)
        case (cfg_index)
          REG_BASE_ADDRESS:   base_reg = cfg_data;
          REG_ANCHORED:       anchored_reg = cfg_data[0];
          REG_ANCHOR_ADDRESS: anchor_reg = cfg_data;
          default: ;
        endcase
      if (s_axis_tvalid && s_axis_tready) begin
        search_step('{mode: s_axis_tuser, value: s_axis_tdata[7:0], wild: s_axis_tdata[8],
                      img: s_axis_tdata[16:9], is_last: s_axis_tlast});
        items_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (item_queue.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 10);
        s_axis_tvalid <= 1'b0;
      end else begin
        next_item = item_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, next_item.img, next_item.wild, next_item.value};
        s_axis_tuser <= next_item.mode;
        s_axis_tlast <= next_item.is_last;
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [17:0] exp_v,
                                 input logic [17:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s of result %0d: expected %h, got %h",
               field, results_seen, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result", '0, m_axis_tdata[17:0]);
      end else begin
        want = expected_reports.pop_front();
        if (m_axis_tdata[0] !== want.hit)
          report_mismatch("hit", 18'(want.hit), 18'(m_axis_tdata[0]));
        if (m_axis_tdata[1] !== want.multi)
          report_mismatch("multiple_hit", 18'(want.multi), 18'(m_axis_tdata[1]));
        if (m_axis_tdata[17:2] !== want.addr)
          report_mismatch("match_address", 18'(want.addr), 18'(m_axis_tdata[17:2]));
      end
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic add_item(input logic [1:0] mode, input logic [7:0] value, input logic wild,
                          input logic [7:0] img, input logic is_last);
    item_queue.push_back('{mode: mode, value: value, wild: wild, img: img, is_last: is_last});
    items_sent++;
    if (mode != MODE_UNUSED) stim_count++;
    if (mode == MODE_CLEAR) plan_pat.delete();
    if (mode == MODE_APPEND && plan_pat.size() < PATTERN_DEPTH) plan_pat.push_back({wild, value});
  endtask

  function automatic logic [7:0] rand_byte(input bit narrow);
    if (narrow) return $urandom_range(0, 1) ? 8'h5A : 8'hA5;
    return 8'($urandom);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every item is taken and every result has come back
  task automatic drain();
    while (items_taken != items_sent || expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_stream(input int len, input int plant, input bit narrow,
                             input bit open, input bit noisy);
    logic [7:0] b;
    for (int n = 0; n < len; n++) begin
      if (noisy && $urandom_range(0, 39) == 0)
        add_item(MODE_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
      if (noisy && $urandom_range(0, 99) == 0)
        add_item(MODE_APPEND, rand_byte(narrow), $urandom_range(0, 3) == 0, 8'($urandom),
                 1'($urandom));
      if (plant >= 0 && n >= plant && n - plant < plan_pat.size() && !plan_pat[n-plant][8])
        b = plan_pat[n-plant][7:0];
      else
        b = rand_byte(narrow);
      add_item(MODE_IMAGE, 8'($urandom), 1'($urandom), b, n == len - 1 && !open);
    end
  endtask

  initial begin
    logic [15:0] base;
    logic [15:0] anchor;
    logic [15:0] offs;
    logic        anch;
    bit          narrow;
    int          plen;
    int          len;
    int          nstreams;
    int          plant;
    int          pick;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pattern, ignored mode, then wildcard pattern hitting twice
    add_item(MODE_IMAGE, 8'h00, 1'b0, 8'h00, 1'b1);
    add_item(MODE_UNUSED, 8'hFF, 1'b1, 8'hFF, 1'b1);
    add_item(MODE_APPEND, 8'h00, 1'b0, 8'hFF, 1'b1);
    add_item(MODE_APPEND, 8'hFF, 1'b1, 8'h00, 1'b0);
    add_item(MODE_APPEND, 8'hFF, 1'b0, 8'h00, 1'b0);
    add_item(MODE_IMAGE, 8'hFF, 1'b1, 8'h00, 1'b0);
    add_item(MODE_IMAGE, 8'h00, 1'b0, 8'h12, 1'b0);
    add_item(MODE_IMAGE, 8'hFF, 1'b1, 8'hFF, 1'b0);
    add_item(MODE_IMAGE, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_IMAGE, 8'hFF, 1'b1, 8'h34, 1'b0);
    add_item(MODE_IMAGE, 8'h00, 1'b0, 8'hFF, 1'b1);
    add_item(MODE_CLEAR, 8'hFF, 1'b1, 8'hFF, 1'b1);
    add_item(MODE_IMAGE, 8'hFF, 1'b1, 8'hFF, 1'b1);
    drain();

    // anchored with addresses wrapping past 0xffff
    write_reg(REG_BASE_ADDRESS, 16'hFFFF);
    write_reg(REG_ANCHORED, 16'h0001);
    write_reg(REG_ANCHOR_ADDRESS, 16'h0001);
    add_item(MODE_APPEND, 8'hAA, 1'b0, 8'h00, 1'b0);
    add_item(MODE_IMAGE, 8'h00, 1'b0, 8'hAA, 1'b0);
    add_item(MODE_IMAGE, 8'h00, 1'b0, 8'hAA, 1'b0);
    add_item(MODE_IMAGE, 8'h00, 1'b0, 8'hAA, 1'b1);
    // pattern longer than the stream
    add_item(MODE_APPEND, 8'hAA, 1'b0, 8'h00, 1'b0);
    add_item(MODE_IMAGE, 8'h00, 1'b0, 8'hAA, 1'b1);

    while (stim_count < ITEM_TARGET) begin
      phases++;
      drain();
      if (stim_count > ITEM_TARGET * 4 / 5) calm = 1'b1;
      quiet = $urandom_range(0, 4) == 0;
      narrow = 1'($urandom_range(0, 1));

      pick = $urandom_range(0, 3);
      base = pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF : pick == 2 ? BASE_RESET :
             16'($urandom);
      anch = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 3);
      anchor = pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF :
               base + 16'($urandom_range(0, 24));
      write_reg(REG_BASE_ADDRESS, base);
      write_reg(REG_ANCHORED, {15'd0, anch});
      write_reg(REG_ANCHOR_ADDRESS, anchor);

      if (plan_pat.size() == 0 || $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 19);
        plen = pick == 0 ? 0 : pick == 1 ? $urandom_range(60, 70) : $urandom_range(1, 6);
        add_item(MODE_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
        for (int i = 0; i < plen; i++)
          add_item(MODE_APPEND, rand_byte(narrow), $urandom_range(0, 3) == 0,
                   8'($urandom), 1'($urandom));
      end

      nstreams = $urandom_range(1, 4);
      for (int s = 0; s < nstreams; s++) begin
        plen = plan_pat.size();
        len = plen + $urandom_range(plen == 0 ? 1 : 0, 20);
        offs = anchor - base;
        if (anch && offs <= len - plen)
          plant = int'(offs);
        else if ($urandom_range(0, 3) == 0)
          plant = -1;
        else
          plant = $urandom_range(0, len - plen);
        send_stream(len, plant, narrow, s == nstreams - 1 && $urandom_range(0, 7) == 0, 1'b1);
      end
    end

    // one anchored stream whose addresses wrap past 0xffff
    drain();
    calm = 1'b1;
    write_reg(REG_BASE_ADDRESS, 16'hFFF0);
    write_reg(REG_ANCHORED, 16'h0001);
    write_reg(REG_ANCHOR_ADDRESS, 16'h0002);
    add_item(MODE_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
    add_item(MODE_APPEND, 8'($urandom), 1'b1, 8'($urandom), 1'($urandom));
    add_item(MODE_APPEND, 8'($urandom), 1'b1, 8'($urandom), 1'($urandom));
    send_stream(LONG_STREAM, -1, 1'b0, 1'b0, 1'b0);
    drain();

    $display("Covered %0d random phases and %0d items, including a %0d-byte anchored stream",
             phases, items_sent, LONG_STREAM);
    $display("Checked %0d search results, %0d mismatching fields", results_seen, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_cell.sv
hw/rtl/wbps_row.sv
hw/rtl/wildcard_byte_pattern_search.sv
tb/tb_wildcard_byte_pattern_search.sv
